// File: hdl/ssr_pkg.sv
// ssr_pkg: shared types, widths and constants for the servo smootherstep ramp
// used by ssr_serial_mul, ssr_shape_eng and smootherstep_servo_ramp_unit
package ssr_pkg;

    localparam int ANGLE_W    = 14;
    localparam int RAMP_STEPS = 256;
    localparam int STEP_W     = $clog2(RAMP_STEPS + 2);
    localparam int REM_W      = $clog2(RAMP_STEPS);
    localparam int V_W        = 17;

    localparam logic [V_W-1:0]     V_INC     = V_W'(65536 / RAMP_STEPS);
    localparam logic [REM_W:0]     REM_INC   = (REM_W + 1)'(65536 % RAMP_STEPS);
    localparam logic [REM_W:0]     REM_MOD   = (REM_W + 1)'(RAMP_STEPS);
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(RAMP_STEPS);

    localparam logic [ANGLE_W-1:0] HOME_ANGLE  = 14'd5760;
    localparam logic [ANGLE_W-1:0] RESET_MAX   = 14'd11520;
    localparam logic [ANGLE_W-1:0] RESET_MIN   = 14'd0;

    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 17;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam int QUAD_W  = 36;
    localparam int Q16_W   = 20;
    localparam int BLEND_W = 31;
    localparam logic [QUAD_W-1:0]  QUAD_C    = 36'hA_0000_0000;
    localparam logic [V_W-1:0]     ONE_Q16   = 17'h10000;
    localparam logic [BLEND_W-1:0] HALF_Q16  = 31'd32768;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [0:0] CFG_MIN_ANGLE = 1'b0;
    localparam logic [0:0] CFG_MAX_ANGLE = 1'b1;

    typedef struct packed {
        logic               op;
        logic [ANGLE_W-1:0] target_angle;
    } t_in_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] position;
        logic               done_res;
        logic               drive_strobe;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic               start;
        logic [V_W-1:0]     v;
        logic [ANGLE_W-1:0] start_pos;
        logic [ANGLE_W-1:0] end_pos;
    } t_eng_req;

    typedef struct packed {
        logic               done;
        logic [ANGLE_W-1:0] position;
    } t_eng_rsp;

    typedef enum logic [1:0] {
        T_IDLE,
        T_LAUNCH,
        T_WAIT
    } t_top_state;

    typedef enum logic [2:0] {
        E_IDLE,
        E_SQ,
        E_QA,
        E_QB,
        E_CUBE,
        E_SMUL,
        E_BL1,
        E_BL2
    } t_eng_state;

endpackage

// File: hdl/ssr_serial_mul.sv
// ssr_serial_mul: radix-2 shift-add multiplier, one multiplier bit per cycle
// depends on ssr_pkg
module ssr_serial_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssr_pkg::t_mul_req i_req,
    output ssr_pkg::t_mul_rsp o_rsp
);

    logic [ssr_pkg::MUL_A_W-1:0]   r_a;
    logic [ssr_pkg::MUL_B_W-1:0]   r_b;
    logic [ssr_pkg::MUL_A_W-1:0]   r_h;
    logic [ssr_pkg::MUL_B_W-1:0]   r_l;
    logic [ssr_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [ssr_pkg::MUL_A_W:0]     sum;

    assign sum = {1'b0, r_h} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ssr_pkg::MUL_CNT_W'(ssr_pkg::MUL_B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ssr_pkg::MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_h <= '0;
            r_l <= '0;
        end else if (r_busy) begin
            r_h <= sum[ssr_pkg::MUL_A_W:1];
            r_l <= {sum[0], r_l[ssr_pkg::MUL_B_W-1:1]};
            r_b <= {1'b0, r_b[ssr_pkg::MUL_B_W-1:1]};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_h, r_l};

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiply launched while busy");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_req.start && r_cnt == ssr_pkg::MUL_CNT_W'(1) |=> r_done)
        else $error("multiply finished without done");

    a_done_past_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("done without a running multiply");

endmodule

// File: hdl/ssr_shape_eng.sv
// ssr_shape_eng: smootherstep and angle blend sequenced over one serial multiplier
// depends on ssr_pkg and ssr_serial_mul
module ssr_shape_eng (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssr_pkg::t_eng_req i_req,
    output ssr_pkg::t_eng_rsp o_rsp
);

    ssr_pkg::t_eng_state r_state;
    ssr_pkg::t_eng_state n_state;
    ssr_pkg::t_mul_req   mul_req;
    ssr_pkg::t_mul_rsp   mul_rsp;

    logic [ssr_pkg::MUL_A_W-1:0] r_v2;
    logic [ssr_pkg::QUAD_W-1:0]  r_quad;
    logic [ssr_pkg::V_W+3:0]     r_t15;
    logic [ssr_pkg::V_W-1:0]     r_s;
    logic [ssr_pkg::BLEND_W-1:0] r_p1;
    logic [ssr_pkg::ANGLE_W-1:0] r_pos;
    logic                        r_done;

    logic [ssr_pkg::V_W+3:0]     s_raw;
    logic [ssr_pkg::V_W-1:0]     s_clip;
    logic [ssr_pkg::BLEND_W-1:0] acc;

    ssr_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // s in Q1.16, saturated at one
    assign s_raw  = mul_rsp.prod[36:16];
    assign s_clip = (s_raw > {4'b0, ssr_pkg::ONE_Q16}) ? ssr_pkg::ONE_Q16
                                                        : s_raw[ssr_pkg::V_W-1:0];
    assign acc    = r_p1 + mul_rsp.prod[ssr_pkg::BLEND_W-1:0] + ssr_pkg::HALF_Q16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssr_pkg::E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (r_state)
            ssr_pkg::E_IDLE: begin
                if (i_req.start) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {{(ssr_pkg::MUL_A_W - ssr_pkg::V_W){1'b0}}, i_req.v};
                    mul_req.b     = i_req.v;
                    n_state       = ssr_pkg::E_SQ;
                end
            end
            ssr_pkg::E_SQ: begin
                if (mul_rsp.done) begin
                    n_state = ssr_pkg::E_QA;
                end
            end
            ssr_pkg::E_QA: begin
                n_state = ssr_pkg::E_QB;
            end
            ssr_pkg::E_QB: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_v2;
                mul_req.b     = i_req.v;
                n_state       = ssr_pkg::E_CUBE;
            end
            ssr_pkg::E_CUBE: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {{(ssr_pkg::MUL_A_W - ssr_pkg::Q16_W){1'b0}},
                                     r_quad[ssr_pkg::QUAD_W-1:16]};
                    mul_req.b     = mul_rsp.prod[48:32];
                    n_state       = ssr_pkg::E_SMUL;
                end
            end
            ssr_pkg::E_SMUL: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {{(ssr_pkg::MUL_A_W - ssr_pkg::ANGLE_W){1'b0}},
                                     i_req.end_pos};
                    mul_req.b     = s_clip;
                    n_state       = ssr_pkg::E_BL1;
                end
            end
            ssr_pkg::E_BL1: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = {{(ssr_pkg::MUL_A_W - ssr_pkg::ANGLE_W){1'b0}},
                                     i_req.start_pos};
                    mul_req.b     = ssr_pkg::ONE_Q16 - r_s;
                    n_state       = ssr_pkg::E_BL2;
                end
            end
            ssr_pkg::E_BL2: begin
                if (mul_rsp.done) begin
                    n_state = ssr_pkg::E_IDLE;
                end
            end
            default: begin
                n_state = ssr_pkg::E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == ssr_pkg::E_BL2) && mul_rsp.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ssr_pkg::E_SQ && mul_rsp.done) begin
            r_v2 <= mul_rsp.prod[ssr_pkg::MUL_A_W-1:0];
        end
        // 6v^2 and 15v, then 6v^2 - 15v + 10 in Q.32
        if (r_state == ssr_pkg::E_QA) begin
            r_quad <= {r_v2, 2'b00} + {1'b0, r_v2, 1'b0};
            r_t15  <= {i_req.v, 4'b0000} - {4'b0000, i_req.v};
        end
        if (r_state == ssr_pkg::E_QB) begin
            r_quad <= r_quad + ssr_pkg::QUAD_C - {r_t15[ssr_pkg::Q16_W-1:0], 16'h0000};
        end
        if (r_state == ssr_pkg::E_SMUL && mul_rsp.done) begin
            r_s <= s_clip;
        end
        if (r_state == ssr_pkg::E_BL1 && mul_rsp.done) begin
            r_p1 <= mul_rsp.prod[ssr_pkg::BLEND_W-1:0];
        end
        if (r_state == ssr_pkg::E_BL2 && mul_rsp.done) begin
            r_pos <= acc[ssr_pkg::ANGLE_W+15:16];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.position = r_pos;

endmodule

// File: hdl/smootherstep_servo_ramp_unit.sv
// smootherstep_servo_ramp_unit: servo ramp top level, move state, handshakes, config
// depends on ssr_pkg and ssr_shape_eng
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in_item  (ssr_pkg::t_in_item)
//  out       output     o_out_valid / i_out_ready  o_out_item (ssr_pkg::t_out_item)
//  cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// start items, idle ticks and ending ticks: result goes to the pending stage on accept, then out
// ticks of a running move: result from the engine after five serial multiplies in sequence
// plus sequencing; next item accepted once the unit is idle and the pending stage is empty
// one item in work at a time; a pending stage lets the next item in while out stalls
// reset is synchronous, active low, and puts the servo at ninety degrees, idle
module smootherstep_servo_ramp_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ssr_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ssr_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [ssr_pkg::ANGLE_W-1:0] i_cfg_data
);

    ssr_pkg::t_top_state r_state;
    ssr_pkg::t_top_state n_state;

    logic [ssr_pkg::ANGLE_W-1:0] r_min;
    logic [ssr_pkg::ANGLE_W-1:0] r_max;
    logic [ssr_pkg::ANGLE_W-1:0] r_start_pos;
    logic [ssr_pkg::ANGLE_W-1:0] r_end_pos;
    logic [ssr_pkg::ANGLE_W-1:0] r_now_pos;
    logic [ssr_pkg::STEP_W-1:0]  r_step;
    logic [ssr_pkg::V_W-1:0]     r_v;
    logic [ssr_pkg::REM_W-1:0]   r_rem;
    logic                        r_finished;

    logic                        r_pend_valid;
    ssr_pkg::t_out_item          r_pend;
    logic                        r_out_valid;
    ssr_pkg::t_out_item          r_out;

    ssr_pkg::t_eng_req           eng_req;
    ssr_pkg::t_eng_rsp           eng_rsp;

    logic                        accept;
    logic                        is_start;
    logic                        calc_tick;
    logic                        end_tick;
    logic                        pend_load;
    logic                        pend_move;
    ssr_pkg::t_out_item          pend_data;
    logic [ssr_pkg::ANGLE_W-1:0] tgt_lo;
    logic [ssr_pkg::ANGLE_W-1:0] tgt_clamp;
    logic [ssr_pkg::REM_W:0]     rem_sum;
    logic                        rem_wrap;

    ssr_shape_eng u_eng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (eng_req),
        .o_rsp   (eng_rsp)
    );

    assign accept    = i_in_valid && o_in_ready;
    assign is_start  = (i_in_item.op == ssr_pkg::OP_START);
    assign calc_tick = accept && !is_start && !r_finished && (r_step < ssr_pkg::STEP_LAST);
    assign end_tick  = accept && !is_start && !r_finished && (r_step >= ssr_pkg::STEP_LAST);

    // max wins when the limits cross
    assign tgt_lo    = (i_in_item.target_angle < r_min) ? r_min : i_in_item.target_angle;
    assign tgt_clamp = (tgt_lo > r_max) ? r_max : tgt_lo;

    // v = floor(k * 65536 / steps) kept as quotient plus remainder
    assign rem_sum  = {1'b0, r_rem} + ssr_pkg::REM_INC;
    assign rem_wrap = (rem_sum >= ssr_pkg::REM_MOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssr_pkg::T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        eng_req.start     = 1'b0;
        eng_req.v         = r_v;
        eng_req.start_pos = r_start_pos;
        eng_req.end_pos   = r_end_pos;
        unique case (r_state)
            ssr_pkg::T_IDLE: begin
                o_in_ready = !r_pend_valid;
                if (calc_tick) begin
                    n_state = ssr_pkg::T_LAUNCH;
                end
            end
            ssr_pkg::T_LAUNCH: begin
                eng_req.start = 1'b1;
                n_state       = ssr_pkg::T_WAIT;
            end
            ssr_pkg::T_WAIT: begin
                if (eng_rsp.done) begin
                    n_state = ssr_pkg::T_IDLE;
                end
            end
            default: begin
                n_state = ssr_pkg::T_IDLE;
            end
        endcase
    end

    always_comb begin
        pend_load = 1'b0;
        pend_data = '0;
        if (eng_rsp.done) begin
            pend_load = 1'b1;
            pend_data = '{position: eng_rsp.position, done_res: 1'b0, drive_strobe: 1'b1};
        end else if (accept && is_start) begin
            pend_load = 1'b1;
            pend_data = '{position: r_start_pos, done_res: 1'b0, drive_strobe: 1'b0};
        end else if (accept && !calc_tick) begin
            pend_load = 1'b1;
            pend_data = '{position: r_now_pos, done_res: 1'b1, drive_strobe: 1'b0};
        end
    end

    assign pend_move = r_pend_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min        <= ssr_pkg::RESET_MIN;
            r_max        <= ssr_pkg::RESET_MAX;
            r_start_pos  <= ssr_pkg::HOME_ANGLE;
            r_end_pos    <= ssr_pkg::HOME_ANGLE;
            r_now_pos    <= ssr_pkg::HOME_ANGLE;
            r_step       <= '0;
            r_v          <= '0;
            r_rem        <= '0;
            r_finished   <= 1'b1;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == ssr_pkg::CFG_MIN_ANGLE) begin
                    r_min <= i_cfg_data;
                end else if (i_cfg_idx == ssr_pkg::CFG_MAX_ANGLE) begin
                    r_max <= i_cfg_data;
                end
            end

            if (accept && is_start) begin
                r_end_pos  <= tgt_clamp;
                r_step     <= '0;
                r_v        <= '0;
                r_rem      <= '0;
                r_finished <= 1'b0;
                r_now_pos  <= r_start_pos;
            end else if (end_tick) begin
                r_step      <= r_step + 1'b1;
                r_finished  <= 1'b1;
                r_start_pos <= r_now_pos;
            end else if (calc_tick) begin
                r_step <= r_step + 1'b1;
                r_v    <= r_v + ssr_pkg::V_INC + ssr_pkg::V_W'(rem_wrap);
                r_rem  <= rem_wrap ? rem_sum[ssr_pkg::REM_W-1:0] -
                                     ssr_pkg::REM_MOD[ssr_pkg::REM_W-1:0]
                                   : rem_sum[ssr_pkg::REM_W-1:0];
            end

            if (eng_rsp.done) begin
                r_now_pos <= eng_rsp.position;
            end

            if (pend_load) begin
                r_pend_valid <= 1'b1;
            end else if (pend_move) begin
                r_pend_valid <= 1'b0;
            end

            if (pend_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_load) begin
            r_pend <= pend_data;
        end
        if (pend_move) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_rsp.done |-> r_state == ssr_pkg::T_WAIT && !r_pend_valid)
        else $error("ramp result arrived outside a running tick");

    a_busy_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ssr_pkg::T_IDLE |-> !r_finished && r_step <= ssr_pkg::STEP_LAST)
        else $error("computing a tick with no move running");

    a_strobe_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.drive_strobe && r_out.done_res))
        else $error("strobe reported on an idle servo");

endmodule
